/* src/radix_digit_converter_core_macros.svh */
// Assertion macros shared by the radix digit converter RTL.
// Included by the top level; has no other dependencies.
`ifndef RADIX_DIGIT_CONVERTER_CORE_MACROS_SVH
`define RADIX_DIGIT_CONVERTER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RDC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rdc assertion failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define RDC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rdc assertion failed one cycle later");

`endif

/* src/rdc_pkg.sv */
// Package for the radix digit converter: widths, sequencer states,
// reciprocal table for the divider and the digit glyph function. No dependencies.
`default_nettype none
package rdc_pkg;

	localparam int VALUE_W        = 31;
	localparam int RADIX_W        = 5;
	localparam int DIGIT_W        = 4;
	localparam int CHAR_W         = 7;
	localparam int MULT_W         = 32;
	localparam int PROD_W         = VALUE_W + MULT_W;
	localparam int MAX_DIGITS_DEF = 32;

	localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
	localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

	localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
	localparam logic [CHAR_W-1:0] CHAR_A    = 7'h41;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_WB,
		ST_POP,
		ST_SEND
	} state_t;

	// Shift code: the quotient is the product shifted right by 32 + code.
	typedef struct packed {
		logic [MULT_W-1:0] mult;
		logic [1:0]        shift;
	} recip_t;

	// Rounded-up reciprocal 2^(31+ceil(log2 b)) / b, exact for every 31-bit dividend.
	function automatic recip_t recip_lookup(input logic [RADIX_W-1:0] base);
		recip_t r;
		unique case (base)
			5'd2:    r = '{mult: 32'd2147483648, shift: 2'd0};
			5'd3:    r = '{mult: 32'd2863311531, shift: 2'd1};
			5'd4:    r = '{mult: 32'd2147483648, shift: 2'd1};
			5'd5:    r = '{mult: 32'd3435973837, shift: 2'd2};
			5'd6:    r = '{mult: 32'd2863311531, shift: 2'd2};
			5'd7:    r = '{mult: 32'd2454267027, shift: 2'd2};
			5'd8:    r = '{mult: 32'd2147483648, shift: 2'd2};
			5'd9:    r = '{mult: 32'd3817748708, shift: 2'd3};
			5'd10:   r = '{mult: 32'd3435973837, shift: 2'd3};
			5'd11:   r = '{mult: 32'd3123612579, shift: 2'd3};
			5'd12:   r = '{mult: 32'd2863311531, shift: 2'd3};
			5'd13:   r = '{mult: 32'd2643056798, shift: 2'd3};
			5'd14:   r = '{mult: 32'd2454267027, shift: 2'd3};
			5'd15:   r = '{mult: 32'd2290649225, shift: 2'd3};
			default: r = '{mult: 32'd2147483648, shift: 2'd3};
		endcase
		return r;
	endfunction

	function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d < 4'd10) begin
			c = CHAR_ZERO + CHAR_W'(d);
		end else begin
			c = CHAR_A + CHAR_W'(d - 4'd10);
		end
		return c;
	endfunction

endpackage
`default_nettype wire

/* src/rdc_divider.sv */
// Shared divider: divides a 31-bit value by a base of 2 to 16 with a
// reciprocal multiply in the start cycle and a shift and remainder fix in the next.
// Depends on rdc_pkg.
`default_nettype none
module rdc_divider (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic [rdc_pkg::VALUE_W-1:0]     dividend,
	input  wire logic [rdc_pkg::RADIX_W-1:0]     base,
	output logic                                 done,
	output logic [rdc_pkg::VALUE_W-1:0]          quotient,
	output logic [rdc_pkg::DIGIT_W-1:0]          remainder
);

	rdc_pkg::recip_t                    recip;
	logic [rdc_pkg::PROD_W-1:0]         product_s1;
	logic [1:0]                         shift_s1;
	logic [rdc_pkg::RADIX_W-1:0]        base_s1;
	logic [rdc_pkg::RADIX_W-1:0]        dividend_lo_s1;
	logic                               done_s1;
	logic [rdc_pkg::RADIX_W-1:0]        qb_lo;
	logic [rdc_pkg::RADIX_W-1:0]        rem_full;

	assign recip = rdc_pkg::recip_lookup(base);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s1 <= 1'b0;
		end else begin
			done_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			product_s1     <= rdc_pkg::PROD_W'(dividend) * rdc_pkg::PROD_W'(recip.mult);
			shift_s1       <= recip.shift;
			base_s1        <= base;
			dividend_lo_s1 <= dividend[rdc_pkg::RADIX_W-1:0];
		end
	end

	always_comb begin
		unique case (shift_s1)
			2'd0:    quotient = product_s1[rdc_pkg::PROD_W-1:32];
			2'd1:    quotient = {1'b0, product_s1[rdc_pkg::PROD_W-1:33]};
			2'd2:    quotient = {2'b00, product_s1[rdc_pkg::PROD_W-1:34]};
			default: quotient = {3'b000, product_s1[rdc_pkg::PROD_W-1:35]};
		endcase
	end

	// The remainder is below sixteen, so the low five bits of n - q * b suffice.
	assign qb_lo     = rdc_pkg::RADIX_W'(quotient[rdc_pkg::RADIX_W-1:0] * base_s1);
	assign rem_full  = dividend_lo_s1 - qb_lo;
	assign remainder = rem_full[rdc_pkg::DIGIT_W-1:0];
	assign done      = done_s1;

endmodule
`default_nettype wire

/* src/rdc_digit_stack.sv */
// Digit stack memory: one write port and one read port with registered
// read data. Depends on rdc_pkg.
`default_nettype none
module rdc_digit_stack #(
	parameter int DEPTH = rdc_pkg::MAX_DIGITS_DEF,
	localparam int AW   = $clog2(DEPTH)
) (
	input  wire logic                          clk,
	input  wire logic                          we,
	input  wire logic [AW-1:0]                 waddr,
	input  wire logic [rdc_pkg::DIGIT_W-1:0]   wdata,
	input  wire logic                          re,
	input  wire logic [AW-1:0]                 raddr,
	output logic [rdc_pkg::DIGIT_W-1:0]        rdata
);

	logic [rdc_pkg::DIGIT_W-1:0] mem_q [DEPTH];
	logic [rdc_pkg::DIGIT_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

/* src/radix_digit_converter_core.sv */
// Radix digit converter top level: sequencer, radix register, shared divider
// and digit stack. Depends on rdc_pkg, rdc_divider, rdc_digit_stack and the macro header.
//
//   channel  | dir | payload
//   ---------+-----+------------------------------------------------
//   s_*      | in  | tdata[30:0] value
//   m_*      | out | tdata[6:0] digit_char, tlast last_digit
//   cfg_*    | in  | cfg_wdata[4:0] radix
//
// A value is accepted in the idle state. Each digit then passes the divider in a multiply
// and a write-back state (reciprocal multiply, then quotient and remainder), and a pop
// and a send state to pop and present it; output stalls hold the send state.
// A zero value is accepted and yields no beat; the block is ready again next cycle.
// Reset clears the sequencer and sets the radix to ten.
`default_nettype none
`include "radix_digit_converter_core_macros.svh"
module radix_digit_converter_core #(
	parameter int MAX_DIGITS = rdc_pkg::MAX_DIGITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [31:0]                     s_tdata,   // [30:0] value
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [7:0]                           m_tdata,   // [6:0] digit_char
	output logic                                 m_tlast,   // last_digit
	input  wire logic                            cfg_we,
	input  wire logic [rdc_pkg::RADIX_W-1:0]     cfg_wdata  // [4:0] radix
);

	localparam int AW = $clog2(MAX_DIGITS);
	localparam int CW = $clog2(MAX_DIGITS + 1);

	rdc_pkg::state_t                    state_q;
	rdc_pkg::state_t                    state_nxt;
	logic [rdc_pkg::RADIX_W-1:0]        radix_q;
	logic [rdc_pkg::VALUE_W-1:0]        n_q;
	logic [CW-1:0]                      cnt_q;
	logic [CW-1:0]                      cnt_inc;
	logic [CW-1:0]                      cnt_dec;
	logic                               in_beat;
	logic                               out_beat;
	logic                               div_start;
	logic                               div_done;
	logic [rdc_pkg::VALUE_W-1:0]        div_quot;
	logic [rdc_pkg::DIGIT_W-1:0]        div_rem;
	logic                               stk_we;
	logic                               stk_re;
	logic [rdc_pkg::DIGIT_W-1:0]        stk_rdata;

	assign in_beat  = s_tvalid && s_tready;
	assign out_beat = m_tvalid && m_tready;
	assign cnt_inc  = cnt_q + CW'(1);
	assign cnt_dec  = cnt_q - CW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= rdc_pkg::RADIX_RESET;
		end else if (cfg_we) begin
			if (cfg_wdata < rdc_pkg::RADIX_MIN) begin
				radix_q <= rdc_pkg::RADIX_MIN;
			end else if (cfg_wdata > rdc_pkg::RADIX_MAX) begin
				radix_q <= rdc_pkg::RADIX_MAX;
			end else begin
				radix_q <= cfg_wdata;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			rdc_pkg::ST_IDLE: begin
				if (in_beat && (s_tdata[rdc_pkg::VALUE_W-1:0] != '0)) begin
					state_nxt = rdc_pkg::ST_MUL;
				end
			end
			rdc_pkg::ST_MUL: begin
				state_nxt = rdc_pkg::ST_WB;
			end
			rdc_pkg::ST_WB: begin
				if (div_done) begin
					if ((div_quot == '0) || (cnt_inc == CW'(MAX_DIGITS))) begin
						state_nxt = rdc_pkg::ST_POP;
					end else begin
						state_nxt = rdc_pkg::ST_MUL;
					end
				end
			end
			rdc_pkg::ST_POP: begin
				state_nxt = rdc_pkg::ST_SEND;
			end
			rdc_pkg::ST_SEND: begin
				if (m_tready) begin
					if (cnt_q == '0) begin
						state_nxt = rdc_pkg::ST_IDLE;
					end else begin
						state_nxt = rdc_pkg::ST_POP;
					end
				end
			end
			default: state_nxt = rdc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready  = 1'b0;
		m_tvalid  = 1'b0;
		div_start = 1'b0;
		stk_we    = 1'b0;
		stk_re    = 1'b0;
		unique case (state_q)
			rdc_pkg::ST_IDLE: s_tready  = 1'b1;
			rdc_pkg::ST_MUL:  div_start = 1'b1;
			rdc_pkg::ST_WB:   stk_we    = div_done;
			rdc_pkg::ST_POP:  stk_re    = 1'b1;
			rdc_pkg::ST_SEND: m_tvalid  = 1'b1;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rdc_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (in_beat) begin
				cnt_q <= '0;
			end else if (stk_we) begin
				cnt_q <= cnt_inc;
			end else if (stk_re) begin
				cnt_q <= cnt_dec;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			n_q <= s_tdata[rdc_pkg::VALUE_W-1:0];
		end else if (stk_we) begin
			n_q <= div_quot;
		end
	end

	rdc_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (n_q),
		.base      (radix_q),
		.done      (div_done),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	rdc_digit_stack #(
		.DEPTH (MAX_DIGITS)
	) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (cnt_q[AW-1:0]),
		.wdata (div_rem),
		.re    (stk_re),
		.raddr (cnt_dec[AW-1:0]),
		.rdata (stk_rdata)
	);

	assign m_tdata = {1'b0, rdc_pkg::glyph(stk_rdata)};
	assign m_tlast = (cnt_q == '0);

	`RDC_ASSERT_SAME(a_no_accept_while_sending, clk, arst_n, m_tvalid, !s_tready)
	`RDC_ASSERT_NEXT(a_nonzero_starts_divide, clk, arst_n,
		in_beat && (s_tdata[rdc_pkg::VALUE_W-1:0] != '0), div_start)
	`RDC_ASSERT_NEXT(a_last_returns_idle, clk, arst_n, out_beat && m_tlast, s_tready)
	`RDC_ASSERT_SAME(a_remainder_below_radix, clk, arst_n, div_done,
		rdc_pkg::RADIX_W'(div_rem) < radix_q)

endmodule
`default_nettype wire

/* sim/rdc_digit_checker.sv */
// Checker for the radix digit converter: watches the value, digit and radix ports,
// predicts the digit beats of every accepted value and compares them in order.
// Depends on rdc_pkg for the field widths.
`default_nettype none
module rdc_digit_checker (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	input  wire logic                        s_tready,
	input  wire logic [31:0]                 s_tdata,   // [30:0] value
	input  wire logic                        m_tvalid,
	input  wire logic                        m_tready,
	input  wire logic [7:0]                  m_tdata,   // [6:0] digit_char
	input  wire logic                        m_tlast,   // last_digit
	input  wire logic                        cfg_we,
	input  wire logic [rdc_pkg::RADIX_W-1:0] cfg_wdata, // [4:0] radix
	output int                               errors,
	output int                               pending
);
	import rdc_pkg::*;

	typedef struct packed {
		logic [CHAR_W-1:0] digit_char;
		logic              last_digit;
	} digit_beat_t;

	digit_beat_t        char_queue[$];
	logic [RADIX_W-1:0] radix;

	initial begin
		errors = 0;
		pending = 0;
	end

	function automatic void queue_digits(input logic [VALUE_W-1:0] value,
			input logic [RADIX_W-1:0] r);
		string       glyphs;
		logic [3:0]  stack [MAX_DIGITS_DEF];
		int unsigned n;
		int unsigned base;
		int          depth;
		digit_beat_t beat;
		glyphs = "0123456789ABCDEF";
		base = (r < 2) ? 2 : (r > 16) ? 16 : r;
		n = value;
		depth = 0;
		while (n != 0 && depth < MAX_DIGITS_DEF) begin
			stack[depth] = 4'(n % base);
			depth++;
			n = n / base;
		end
		for (int i = depth - 1; i >= 0; i--) begin
			beat.digit_char = CHAR_W'(glyphs[stack[i]]);
			beat.last_digit = (i == 0);
			char_queue.push_back(beat);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		digit_beat_t want;
		if (!arst_n) begin
			char_queue.delete();
			radix = RADIX_RESET;
		end else begin
			if (m_tvalid && m_tready) begin
				if (char_queue.size() == 0) begin
					$error("unexpected beat: digit_char %0h last_digit %0b",
						m_tdata[CHAR_W-1:0], m_tlast);
					errors++;
				end else begin
					want = char_queue.pop_front();
					if (m_tdata[CHAR_W-1:0] !== want.digit_char) begin
						$error("digit_char: expected %0h, actual %0h",
							want.digit_char, m_tdata[CHAR_W-1:0]);
						errors++;
					end
					if (m_tlast !== want.last_digit) begin
						$error("last_digit: expected %0b, actual %0b",
							want.last_digit, m_tlast);
						errors++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				queue_digits(s_tdata[VALUE_W-1:0], radix);
			end
			if (cfg_we) begin
				radix = cfg_wdata;
			end
		end
		pending = char_queue.size();
	end

endmodule
`default_nettype wire

/* sim/tb.sv */
// Testbench top for the radix digit converter: clock, reset, value and radix stimulus,
// a stalling digit receiver, a watchdog and the verdict.
// Depends on rdc_pkg, radix_digit_converter_core and rdc_digit_checker.
`default_nettype none
module tb;
	import rdc_pkg::*;

	localparam int SETTLE_CYCLES = 10;
	localparam int DRAIN_CYCLES  = 130;
	localparam int HOLD_CYCLES   = 400;
	localparam int STALL_LIMIT   = 3000;
	localparam int PHASE_ITEMS   = 27;

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [31:0]        s_tdata;   // [30:0] value
	logic               m_tvalid;
	logic               m_tready;
	logic [7:0]         m_tdata;   // [6:0] digit_char
	logic               m_tlast;   // last_digit
	logic               cfg_we;
	logic [RADIX_W-1:0] cfg_wdata; // [4:0] radix
	int                 errors;
	int                 pending;
	bit                 steady;
	bit                 squeeze;
	int                 stalled;

	radix_digit_converter_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	rdc_digit_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.errors    (errors),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
	end

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic send_value(input logic [VALUE_W-1:0] value);
		if (!steady) begin
			while ($urandom_range(99) < 20) begin
				s_tvalid <= 1'b0;
				@(negedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, value};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic drain(input int settle);
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (settle) @(negedge clk);
	endtask

	task automatic write_radix(input logic [RADIX_W-1:0] r);
		drain(SETTLE_CYCLES);
		cfg_we <= 1'b1;
		cfg_wdata <= r;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [VALUE_W-1:0] pick_value();
		int unsigned        roll;
		int unsigned        w;
		logic [VALUE_W-1:0] v;
		roll = $urandom_range(99);
		w = $urandom_range(VALUE_W, 1);
		v = VALUE_W'($urandom) >> (VALUE_W - w);
		if (roll < 5) begin
			v = '0;
		end else if (roll < 10) begin
			v = {VALUE_W{1'b1}} >> (VALUE_W - w);
		end else if (roll < 14) begin
			v = {VALUE_W{1'b1}};
		end else if (roll < 40) begin
			v = VALUE_W'($urandom);
		end
		return v;
	endfunction

	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (squeeze) begin
				squeeze <= 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			m_tready <= steady || ($urandom_range(99) >= 20);
		end
	end

	initial begin
		stalled = 0;
		while (stalled < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				stalled = 0;
			end else begin
				stalled++;
			end
		end
		$display("tb: errors");
		$finish;
	end

	initial begin
		logic [RADIX_W-1:0] phase_radix [6];
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// The reset radix of ten, then both ends of the base range, out-of-range bases, and bases three and seven.
		send_value(31'd0);
		send_value(31'd1);
		send_value(31'd9);
		send_value(31'd10);
		send_value(31'd1000000000);
		send_value(31'h7FFFFFFF);
		write_radix(5'd2);
		send_value(31'd1);
		send_value(31'h40000000);
		send_value(31'h7FFFFFFF);
		write_radix(5'd16);
		send_value(31'd15);
		send_value(31'd16);
		send_value(31'd0);
		send_value(31'h7FFFFFFF);
		write_radix(5'd0);
		send_value(31'd5);
		write_radix(5'd1);
		send_value(31'd6);
		write_radix(5'd17);
		send_value(31'd255);
		write_radix(5'd31);
		send_value(31'h7FFFFFFF);
		write_radix(5'd3);
		send_value(31'h7FFFFFFF);
		write_radix(5'd7);
		send_value(31'd48);

		phase_radix[0] = 5'd2;
		phase_radix[1] = 5'd16;
		phase_radix[2] = RADIX_W'($urandom_range(15, 3));
		phase_radix[3] = RADIX_W'($urandom_range(31, 0));
		phase_radix[4] = RADIX_W'($urandom_range(16, 2));
		phase_radix[5] = 5'd10;
		for (int p = 0; p < 6; p++) begin
			write_radix(phase_radix[p]);
			steady = (p == 2);
			if (p == 0) begin
				squeeze <= 1'b1;
			end
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				send_value(pick_value());
			end
		end

		steady = 1'b0;
		drain(DRAIN_CYCLES);
		if (errors == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

endmodule
`default_nettype wire

/* radix_digit_converter_core.f */
+incdir+src
src/rdc_pkg.sv
src/rdc_divider.sv
src/rdc_digit_stack.sv
src/radix_digit_converter_core.sv
sim/rdc_digit_checker.sv
sim/tb.sv
